### src/rar_pkg.sv
// Shared types and constants for the rational arithmetic reduce unit.
`default_nettype none
package rar_pkg;
	localparam int VALUE_BITS = 16;
	localparam int NUM_W  = VALUE_BITS;
	localparam int DEN_W  = VALUE_BITS - 1;
	localparam int RNUM_W = 2 * VALUE_BITS;
	localparam int RDEN_W = 2 * VALUE_BITS - 2;
	localparam int ACC_W  = 2 * VALUE_BITS + 2;
	localparam int GCD_W  = 2 * VALUE_BITS;
	localparam int MCNT_W = $clog2(NUM_W);
	localparam int DCNT_W = $clog2(GCD_W);
	localparam int SHF_W  = $clog2(GCD_W);

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_ADD = 2'd0;
	localparam mode_t MODE_SUB = 2'd1;
	localparam mode_t MODE_MUL = 2'd2;
	localparam mode_t MODE_DIV = 2'd3;

	// request into the reduction unit
	typedef struct packed {
		logic             start;
		logic [GCD_W-1:0] mag;
		logic [GCD_W-1:0] den;
	} red_req_t;

	// reply from the reduction unit
	typedef struct packed {
		logic             done;
		logic [GCD_W-1:0] quo_num;
		logic [GCD_W-1:0] quo_den;
	} red_rsp_t;
endpackage
`default_nettype wire

### src/rar_if.sv
// Request channel interfaces for operands and results.
`default_nettype none
interface rar_in_if import rar_pkg::*; ();
	logic              valid;
	logic              ready;
	mode_t             mode;
	logic signed [NUM_W-1:0] a_num;
	logic [DEN_W-1:0]  a_den;
	logic signed [NUM_W-1:0] b_num;
	logic [DEN_W-1:0]  b_den;
	modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
	modport sink   (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if import rar_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [RNUM_W-1:0] res_num;
	logic [RDEN_W-1:0]  res_den;
	logic               zero_divide;
	modport source (output valid, res_num, res_den, zero_divide, input ready);
	modport sink   (input valid, res_num, res_den, zero_divide, output ready);
endinterface
`default_nettype wire

### src/rar_reduce.sv
// Binary GCD and bit-serial restoring divide of a fraction by its GCD.
`default_nettype none
module rar_reduce import rar_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire red_req_t req,
	output red_rsp_t      rsp
);
	localparam logic [2:0] R_IDLE = 3'd0;
	localparam logic [2:0] R_TWO  = 3'd1;
	localparam logic [2:0] R_GCD  = 3'd2;
	localparam logic [2:0] R_SHL  = 3'd3;
	localparam logic [2:0] R_DIV  = 3'd4;
	localparam logic [2:0] R_DONE = 3'd5;

	logic [2:0]        state_q;
	logic [GCD_W-1:0]  u_q, v_q, g_q, x_q, y_q, remx_q, remy_q;
	logic [SHF_W-1:0]  k_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [GCD_W-1:0]  remx_sh, remy_sh;
	logic              qx, qy;

	assign remx_sh = {remx_q[GCD_W-2:0], x_q[GCD_W-1]};
	assign remy_sh = {remy_q[GCD_W-2:0], y_q[GCD_W-1]};
	assign qx = (remx_sh >= g_q);
	assign qy = (remy_sh >= g_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				R_IDLE: begin
					if (req.start) begin
						state_q <= R_TWO;
						k_q     <= '0;
					end
				end
				R_TWO: if (u_q[0] || v_q[0]) state_q <= R_GCD;
				else k_q <= k_q + 1'b1;
				R_GCD: if (u_q == '0) state_q <= R_SHL;
				R_SHL: begin
					if (k_q == '0) begin
						state_q <= R_DIV;
						cnt_q   <= '0;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				R_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DCNT_W'(GCD_W - 1)) state_q <= R_DONE;
				end
				R_DONE: state_q <= R_IDLE;
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				u_q <= req.mag;
				v_q <= req.den;
				x_q <= req.mag;
				y_q <= req.den;
			end
			R_TWO: if (!(u_q[0] || v_q[0])) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
			end
			R_GCD: begin
				if (u_q == '0) g_q <= v_q;
				else if (!u_q[0]) u_q <= u_q >> 1;
				else if (!v_q[0]) v_q <= v_q >> 1;
				else if (u_q >= v_q) u_q <= u_q - v_q;
				else v_q <= v_q - u_q;
				remx_q <= '0;
				remy_q <= '0;
			end
			R_SHL: if (k_q != '0) g_q <= g_q << 1;
			R_DIV: begin
				remx_q <= qx ? remx_sh - g_q : remx_sh;
				remy_q <= qy ? remy_sh - g_q : remy_sh;
				x_q    <= {x_q[GCD_W-2:0], qx};
				y_q    <= {y_q[GCD_W-2:0], qy};
			end
			default: ;
		endcase
	end

	assign rsp.done    = (state_q == R_DONE);
	assign rsp.quo_num = x_q;
	assign rsp.quo_den = y_q;
endmodule
`default_nettype wire

### src/rational_arith_reduce_unit.sv
// Top level: rational add/sub/mul/div with reduction to lowest terms.
// Flow: when the result is 0/1 or the denominator is zero, the reduction is skipped;
// otherwise the result waits for the binary GCD loop (one shift or subtract per cycle)
// and then the bit-serial divide by the GCD.
// Throughput: one request at a time; the next is taken once the result is held.
// Reset: arst_n clears control and the output valid; payload is not reset.
`default_nettype none
module rational_arith_reduce_unit import rar_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	rar_in_if.sink   in_ch,
	rar_out_if.source out_ch
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_SUM  = 3'd2;
	localparam logic [2:0] S_FIX  = 3'd3;
	localparam logic [2:0] S_RED  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]        state_q;
	mode_t             mode_q;
	logic              zdiv_q, neg_q;
	// three shift-add multipliers, one multiplier bit per cycle
	logic [ACC_W-1:0]  mca_q, mcb_q, mcd_q, acca_q, accb_q, accd_q;
	logic [NUM_W-1:0]  sra_q, srb_q, srd_q;
	logic [MCNT_W-1:0] cnt_q;
	logic [ACC_W-1:0]  n_q, d_q;
	logic [RNUM_W-1:0] rnum_q;
	logic [RDEN_W-1:0] rden_q;
	logic              out_valid_q;
	logic signed [RNUM_W-1:0] out_num_q;
	logic [RDEN_W-1:0] out_den_q;
	logic              out_zd_q;

	logic              last_bit, d_nonpos, accept, out_load;
	logic [ACC_W-1:0]  n_neg, n_mag, d_pos;
	red_req_t          red_req;
	red_rsp_t          red_rsp;

	// one partial product; the sign bit of the serial operand weighs negative
	function automatic logic [ACC_W-1:0] mac(input logic [ACC_W-1:0] acc,
		input logic [ACC_W-1:0] mc, input logic b, input logic last);
		if (!b) return acc;
		return last ? acc - mc : acc + mc;
	endfunction

	assign accept   = in_ch.valid && in_ch.ready;
	assign last_bit = (cnt_q == MCNT_W'(NUM_W - 1));
	assign d_nonpos = d_q[ACC_W-1] || (d_q == '0);
	assign n_neg    = -n_q;
	assign n_mag    = n_q[ACC_W-1] ? n_neg : n_q;
	assign d_pos    = d_nonpos ? -d_q : d_q;
	// output register takes a new result when empty or being drained
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ch.ready);

	assign red_req.start = (state_q == S_FIX) && (d_q != '0) && (n_q != '0);
	assign red_req.mag   = n_mag[GCD_W-1:0];
	assign red_req.den   = d_pos[GCD_W-1:0];

	rar_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (red_req),
		.rsp    (red_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (accept) begin
					state_q <= S_MUL;
					cnt_q   <= '0;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_bit) state_q <= S_SUM;
				end
				S_SUM: state_q <= S_FIX;
				S_FIX: state_q <= red_req.start ? S_RED : S_OUT;
				S_RED: if (red_rsp.done) state_q <= S_OUT;
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q <= in_ch.mode;
				zdiv_q <= (in_ch.mode == MODE_DIV) && (in_ch.b_num == '0);
				mca_q  <= ACC_W'(in_ch.a_num);
				mcb_q  <= ACC_W'(in_ch.b_num);
				mcd_q  <= {{(ACC_W-DEN_W){1'b0}}, in_ch.a_den};
				sra_q  <= (in_ch.mode == MODE_MUL) ? in_ch.b_num : {1'b0, in_ch.b_den};
				srb_q  <= (in_ch.mode == MODE_ADD || in_ch.mode == MODE_SUB) ?
					{1'b0, in_ch.a_den} : '0;
				srd_q  <= (in_ch.mode == MODE_DIV) ? in_ch.b_num : {1'b0, in_ch.b_den};
				acca_q <= '0;
				accb_q <= '0;
				accd_q <= '0;
			end
			S_MUL: begin
				acca_q <= mac(acca_q, mca_q, sra_q[0], last_bit);
				accb_q <= mac(accb_q, mcb_q, srb_q[0], last_bit);
				accd_q <= mac(accd_q, mcd_q, srd_q[0], last_bit);
				mca_q  <= mca_q << 1;
				mcb_q  <= mcb_q << 1;
				mcd_q  <= mcd_q << 1;
				sra_q  <= sra_q >> 1;
				srb_q  <= srb_q >> 1;
				srd_q  <= srd_q >> 1;
			end
			S_SUM: begin
				n_q <= (mode_q == MODE_SUB) ? acca_q - accb_q : acca_q + accb_q;
				d_q <= accd_q;
			end
			S_FIX: begin
				// result sign flips when the denominator was negative
				neg_q <= n_q[ACC_W-1] ^ d_q[ACC_W-1];
				if (d_q == '0) begin
					// zero denominator: negated numerator over zero
					rnum_q <= n_neg[RNUM_W-1:0];
					rden_q <= '0;
				end else begin
					rnum_q <= '0;
					rden_q <= RDEN_W'(1);
				end
			end
			S_RED: if (red_rsp.done) begin
				rnum_q <= neg_q ? -red_rsp.quo_num : red_rsp.quo_num;
				rden_q <= red_rsp.quo_den[RDEN_W-1:0];
			end
			S_OUT: if (out_load) begin
				out_num_q <= rnum_q;
				out_den_q <= rden_q;
				out_zd_q  <= zdiv_q;
			end
			default: ;
		endcase
	end

	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.res_num     = out_num_q;
	assign out_ch.res_den     = out_den_q;
	assign out_ch.zero_divide = out_zd_q;
endmodule
`default_nettype wire

### src/rar_checker.sv
// Port-level assertions for the rational arithmetic reduce unit, with bind.
`default_nettype none
module rar_checker import rar_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [RNUM_W-1:0] res_num,
	input wire logic [RDEN_W-1:0] res_den,
	input wire logic              zero_divide
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new request taken while busy");
	a_zdiv_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_divide |-> res_den == '0)
		else $error("zero divide with nonzero denominator");
	a_zero_num: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_num == '0 && res_den != '0 |-> res_den == RDEN_W'(1))
		else $error("zero result not 0/1");
endmodule

bind rational_arith_reduce_unit rar_checker u_rar_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.res_num     (out_ch.res_num),
	.res_den     (out_ch.res_den),
	.zero_divide (out_ch.zero_divide)
);
`default_nettype wire
